// ===== hdl/hsv_to_rgb_converter_assert.svh =====
// Assertion macros shared by the checker of the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define HSV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define HSV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/hsv2rgb_pkg.sv =====
// Types, constants and helper functions of the HSV to RGB converter.
`timescale 1ns / 1ps
package hsv2rgb_pkg;

  localparam int CHAN_W     = 16;
  localparam int PIPE_DEPTH = 5;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [2:0]        sector_t;

  // Hue sectors, named after the two primaries or secondaries they span.
  localparam sector_t SEC_RED_YEL = 3'd0;
  localparam sector_t SEC_YEL_GRN = 3'd1;
  localparam sector_t SEC_GRN_CYN = 3'd2;
  localparam sector_t SEC_CYN_BLU = 3'd3;
  localparam sector_t SEC_BLU_MAG = 3'd4;
  localparam sector_t SEC_MAG_RED = 3'd5;

  localparam logic [32:0] ROUND_UNIT = 33'd32767;

  // Rounded division of a product of two unit values by 65535.
  // With y = prod + 32767 = 65535*k + r, (y + (y >> 16) + 1) >> 16 equals k
  // for every k up to 65536, which covers the whole product range.
  function automatic chan_t div_unit(input logic [31:0] prod);
    logic [32:0] y;
    logic [32:0] z;
    y = {1'b0, prod} + ROUND_UNIT;
    z = y + (y >> 16) + 33'd1;
    return z[31:16];
  endfunction

endpackage

// ===== hdl/hsv2rgb_ifs.sv =====
// Channel interfaces of the HSV to RGB converter: pixel in, pixel out.
`timescale 1ns / 1ps
interface hsv2rgb_in_if import hsv2rgb_pkg::*;;
  logic  valid;
  logic  ready;
  chan_t hue;
  chan_t saturation;
  chan_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_out_if import hsv2rgb_pkg::*;;
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hdl/hsv_to_rgb_converter.sv =====
// Top level of the pipelined HSV to RGB color converter.
//
// One pixel beat enters on in_pix (hue, saturation, brightness, 16 bits each)
// and one beat leaves on out_pix (red, green, blue, 16 bits each). Both
// channels move a beat when valid and ready are high at a rising clock edge.
// Hue is a fraction of a full turn (hue/65536); all other fields are x/65535.
//
// The datapath is a five-stage pipeline: sector split, first multiplies,
// rounding, second multiplies, then division by 65535 and channel ordering.
// Throughput is one pixel per cycle while out_pix.ready stays high.
//
// Each stage has its own valid bit and advances when it is empty or the
// stage ahead advances, so bubbles close up. When the receiver holds
// out_pix.ready low the pipeline fills and then in_pix.ready drops; nothing
// is lost or repeated. A synchronous low rst_n empties all stages.
// FRAC_BITS sets the precision of the hue fraction (8 to 24).
`timescale 1ns / 1ps
module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input logic          clk,
  input logic          rst_n,
  hsv2rgb_in_if.sink   in_pix,
  hsv2rgb_out_if.source out_pix
);

  localparam logic [FRAC_BITS:0]    ONE_FRAC = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+15:0] HALF_SF  = (FRAC_BITS+16)'(1) << (FRAC_BITS-1);

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic [PIPE_DEPTH-1:0] stg_en;

  // Stage 1: sector and fraction.
  logic [18:0]          hue6;
  logic [15:0]          frac16;
  logic [FRAC_BITS-1:0] frac;
  sector_t              s1_sec_r;
  chan_t                s1_sat_r;
  chan_t                s1_bri_r;
  logic [FRAC_BITS-1:0] s1_f_r;
  logic [FRAC_BITS:0]   s1_omf_r;

  // Stage 2: saturation products and the p product.
  logic [FRAC_BITS+15:0] sf_prod;
  logic [FRAC_BITS+16:0] st_prod;
  logic [31:0]           pp_prod;
  logic [FRAC_BITS+15:0] s2_sf_r;
  logic [FRAC_BITS+16:0] s2_st_r;
  logic [31:0]           s2_pp_r;
  sector_t               s2_sec_r;
  chan_t                 s2_bri_r;

  // Stage 3: rounded saturation terms, complemented.
  logic [FRAC_BITS+15:0] sq_sum;
  logic [FRAC_BITS+16:0] st_sum;
  chan_t                 s3_yq_r;
  chan_t                 s3_yt_r;
  logic [31:0]           s3_pp_r;
  sector_t               s3_sec_r;
  chan_t                 s3_bri_r;

  // Stage 4: brightness products for q and t.
  logic [31:0] s4_pq_r;
  logic [31:0] s4_pt_r;
  logic [31:0] s4_pp_r;
  sector_t     s4_sec_r;
  chan_t       s4_bri_r;

  // Stage 5: output register.
  chan_t p_val;
  chan_t q_val;
  chan_t t_val;
  chan_t red_nxt;
  chan_t green_nxt;
  chan_t blue_nxt;
  chan_t out_red_r;
  chan_t out_green_r;
  chan_t out_blue_r;

  // A stage advances when it is empty or the stage ahead of it advances.
  always_comb begin
    stg_en[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || out_pix.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (stg_en[0]) begin
      vld_nxt[0] = in_pix.valid;
    end
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      if (stg_en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_pix.ready  = stg_en[0];
  assign out_pix.valid = vld_r[PIPE_DEPTH-1];
  assign out_pix.red   = out_red_r;
  assign out_pix.green = out_green_r;
  assign out_pix.blue  = out_blue_r;

  // Hue times six: the top three bits are the sector, the low 16 the fraction.
  assign hue6   = 19'(in_pix.hue) * 19'd6;
  assign frac16 = hue6[15:0];

  generate
    if (FRAC_BITS >= 16) begin : g_frac_wide
      assign frac = FRAC_BITS'(frac16) << (FRAC_BITS - 16);
    end else begin : g_frac_narrow
      assign frac = FRAC_BITS'(frac16 >> (16 - FRAC_BITS));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      s1_sec_r <= hue6[18:16];
      s1_sat_r <= in_pix.saturation;
      s1_bri_r <= in_pix.brightness;
      s1_f_r   <= frac;
      s1_omf_r <= ONE_FRAC - {1'b0, frac};
    end
  end

  assign sf_prod = s1_sat_r * s1_f_r;
  assign st_prod = s1_sat_r * s1_omf_r;
  assign pp_prod = s1_bri_r * chan_t'(~s1_sat_r);

  always_ff @(posedge clk) begin
    if (stg_en[1]) begin
      s2_sf_r  <= sf_prod;
      s2_st_r  <= st_prod;
      s2_pp_r  <= pp_prod;
      s2_sec_r <= s1_sec_r;
      s2_bri_r <= s1_bri_r;
    end
  end

  // Rounded half up; the rounded term never exceeds the saturation, so the
  // complement is 65535 minus it.
  assign sq_sum = s2_sf_r + HALF_SF;
  assign st_sum = s2_st_r + {1'b0, HALF_SF};

  always_ff @(posedge clk) begin
    if (stg_en[2]) begin
      s3_yq_r  <= ~sq_sum[FRAC_BITS+15:FRAC_BITS];
      s3_yt_r  <= ~st_sum[FRAC_BITS+15:FRAC_BITS];
      s3_pp_r  <= s2_pp_r;
      s3_sec_r <= s2_sec_r;
      s3_bri_r <= s2_bri_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[3]) begin
      s4_pq_r  <= s3_bri_r * s3_yq_r;
      s4_pt_r  <= s3_bri_r * s3_yt_r;
      s4_pp_r  <= s3_pp_r;
      s4_sec_r <= s3_sec_r;
      s4_bri_r <= s3_bri_r;
    end
  end

  assign p_val = div_unit(s4_pp_r);
  assign q_val = div_unit(s4_pq_r);
  assign t_val = div_unit(s4_pt_r);

  always_comb begin
    case (s4_sec_r)
      SEC_RED_YEL: begin
        red_nxt = s4_bri_r; green_nxt = t_val;    blue_nxt = p_val;
      end
      SEC_YEL_GRN: begin
        red_nxt = q_val;    green_nxt = s4_bri_r; blue_nxt = p_val;
      end
      SEC_GRN_CYN: begin
        red_nxt = p_val;    green_nxt = s4_bri_r; blue_nxt = t_val;
      end
      SEC_CYN_BLU: begin
        red_nxt = p_val;    green_nxt = q_val;    blue_nxt = s4_bri_r;
      end
      SEC_BLU_MAG: begin
        red_nxt = t_val;    green_nxt = p_val;    blue_nxt = s4_bri_r;
      end
      default: begin
        red_nxt = s4_bri_r; green_nxt = p_val;    blue_nxt = q_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stg_en[4]) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
    end
  end

endmodule

// ===== hdl/hsv2rgb_checker.sv =====
// Port-level checker for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_assert.svh"
module hsv2rgb_port_checker import hsv2rgb_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input chan_t red,
  input chan_t green,
  input chan_t blue
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic              in_acc;
  logic              out_acc;
  logic              out_stall;
  logic [3*CHAN_W-1:0] out_rgb;
  logic [CNT_W-1:0]  inflight_r;
  logic [CNT_W-1:0]  inflight_nxt;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_rgb   = {red, green, blue};

  // Beats accepted at the input and not yet delivered at the output.
  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      inflight_nxt = inflight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `HSV_ASSERT_NOW(a_no_invented_beat, out_valid, inflight_r != '0, "output beat without input")
  `HSV_ASSERT_NOW(a_depth_bound, 1'b1, inflight_r <= CNT_W'(PIPE_DEPTH), "too many beats held")
  `HSV_ASSERT_NOW(a_ready_flows, out_ready, in_ready, "input stalled while output drains")
  `HSV_ASSERT_NEXT(a_stall_holds, out_stall, out_valid && $stable(out_rgb), "stalled output changed")

endmodule

bind hsv_to_rgb_converter hsv2rgb_port_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .red       (out_pix.red),
  .green     (out_pix.green),
  .blue      (out_pix.blue)
);

// ===== dv/hsv2rgb_checker.sv =====
// Checker for the HSV to RGB converter: predicts each pixel and compares output beats.
`timescale 1ns / 1ps
module hsv2rgb_checker import hsv2rgb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_ready,
  input  chan_t in_hue,
  input  chan_t in_saturation,
  input  chan_t in_brightness,
  input  logic  out_valid,
  input  logic  out_ready,
  input  chan_t out_red,
  input  chan_t out_green,
  input  chan_t out_blue,
  output int    pending_count,
  output int    mismatch_count
);

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  rgb_t expected_rgb[$];
  int   error_total = 0;

  // Product of two unit values, divided by 65535 with rounding half up.
  function automatic chan_t scale_unit(input bit [63:0] a, input bit [63:0] b);
    return chan_t'((a * b + 64'd32767) / 64'd65535);
  endfunction

  // Saturation times a hue fraction, rounded back to the saturation scale.
  function automatic bit [63:0] scale_sat(input bit [63:0] s, input bit [63:0] x);
    return (s * x + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  endfunction

  function automatic rgb_t hsv_to_rgb(input chan_t h, input chan_t s, input chan_t v);
    bit [31:0] h6;
    sector_t   sector;
    bit [63:0] frac;
    bit [63:0] one;
    chan_t     p;
    chan_t     q;
    chan_t     t;
    rgb_t      c;
    h6     = 32'(h) * 32'd6;
    sector = sector_t'((h6 >> 16) % 6);
    frac   = 64'(h6[15:0]);
    if (FRAC_BITS >= 16) begin
      frac = frac << (FRAC_BITS - 16);
    end else begin
      frac = frac >> (16 - FRAC_BITS);
    end
    one = 64'd1 << FRAC_BITS;
    p   = scale_unit(v, 64'd65535 - s);
    q   = scale_unit(v, 64'd65535 - scale_sat(s, frac));
    t   = scale_unit(v, 64'd65535 - scale_sat(s, one - frac));
    c   = '{red: v, green: p, blue: q};
    case (sector)
      SEC_RED_YEL: c = '{red: v, green: t, blue: p};
      SEC_YEL_GRN: c = '{red: q, green: v, blue: p};
      SEC_GRN_CYN: c = '{red: p, green: v, blue: t};
      SEC_CYN_BLU: c = '{red: p, green: q, blue: v};
      SEC_BLU_MAG: c = '{red: t, green: p, blue: v};
      SEC_MAG_RED: c = '{red: v, green: p, blue: q};
      default:     c = '{red: v, green: p, blue: q};
    endcase
    return c;
  endfunction

  always @(posedge clk) begin : monitor
    rgb_t want;
    rgb_t got;
    if (!rst_n) begin
      expected_rgb.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_rgb.push_back(hsv_to_rgb(in_hue, in_saturation, in_brightness));
      end
      if (out_valid && out_ready) begin
        got = '{red: out_red, green: out_green, blue: out_blue};
        if (expected_rgb.size() == 0) begin
          if (error_total < 10) begin
            $display("%0t: output beat with no pixel pending: r=%h g=%h b=%h",
                     $realtime, got.red, got.green, got.blue);
          end
          error_total++;
        end else begin
          want = expected_rgb.pop_front();
          if (got != want) begin
            if (error_total < 10) begin
              $display("%0t: pixel mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                       $realtime, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
            end
            error_total++;
          end
        end
      end
    end
    pending_count  <= expected_rgb.size();
    mismatch_count <= error_total;
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the HSV to RGB converter testbench: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import hsv2rgb_pkg::*;

  localparam int FRAC_BITS    = 16;
  localparam int RANDOM_ITEMS = 850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DIRECTED_N   = 22;

  // Each entry is {hue, saturation, brightness}. The hue values sit on both
  // sides of every sector boundary but 32768, and 0 and 32768 give a zero fraction.
  localparam logic [47:0] DIRECTED [DIRECTED_N] = '{
    {16'd0,     16'd0,     16'd0},
    {16'd65535, 16'd65535, 16'd65535},
    {16'd0,     16'd65535, 16'd65535},
    {16'd32768, 16'd65535, 16'd65535},
    {16'd10922, 16'd65535, 16'd65535},
    {16'd10923, 16'd65535, 16'd65535},
    {16'd21845, 16'd65535, 16'd65535},
    {16'd21846, 16'd65535, 16'd65535},
    {16'd43690, 16'd65535, 16'd65535},
    {16'd43691, 16'd65535, 16'd65535},
    {16'd54613, 16'd65535, 16'd65535},
    {16'd54614, 16'd65535, 16'd65535},
    {16'd12345, 16'd0,     16'd40000},
    {16'd50000, 16'd65535, 16'd0},
    {16'd16384, 16'd32768, 16'd32768},
    {16'd49152, 16'd1,     16'd65535},
    {16'd5461,  16'd65534, 16'd1},
    {16'd0,     16'd65535, 16'd12345},
    {16'd32768, 16'd40000, 16'd50000},
    {16'd60000, 16'd65535, 16'd65535},
    {16'd27000, 16'd20000, 16'd65535},
    {16'd65535, 16'd0,     16'd65535}
  };

  typedef enum logic [2:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE, RX_HOLD} rx_mode_e;

  logic     clk;
  logic     rst_n;
  int       pending_count;
  int       mismatch_count;
  int       idle_cycles = 0;
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  bit [7:0] rx_phase = '0;

  hsv2rgb_in_if  in_pix ();
  hsv2rgb_out_if out_pix ();

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  hsv_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  hsv2rgb_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_pix.valid),
    .in_ready       (in_pix.ready),
    .in_hue         (in_pix.hue),
    .in_saturation  (in_pix.saturation),
    .in_brightness  (in_pix.brightness),
    .out_valid      (out_pix.valid),
    .out_ready      (out_pix.ready),
    .out_red        (out_pix.red),
    .out_green      (out_pix.green),
    .out_blue       (out_pix.blue),
    .pending_count  (pending_count),
    .mismatch_count (mismatch_count)
  );

  // The receiver moves between stall modes, each held for a random stretch.
  always @(posedge clk) begin : receiver
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 4));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:  out_pix.ready <= 1'b1;
      RX_LIGHT: out_pix.ready <= ($urandom_range(0, 9) != 0);
      RX_HEAVY: out_pix.ready <= ($urandom_range(0, 2) == 0);
      RX_PULSE: out_pix.ready <= (rx_phase[1:0] != 2'd0);
      default:  out_pix.ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly uniform values, with a share of extremes and, for hue, values
  // just around the sector boundaries.
  function automatic chan_t pick_field(input bit is_hue);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return is_hue ? 16'((32'($urandom_range(0, 6)) * 32'd65536) / 32'd6
                             + 32'($urandom_range(0, 4)) - 32'd2)
                       : 16'($urandom_range(0, 3));
      3: return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input chan_t h, input chan_t s, input chan_t v);
    in_pix.valid      <= 1'b1;
    in_pix.hue        <= h;
    in_pix.saturation <= s;
    in_pix.brightness <= v;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
  endtask

  // The pending count is registered, so it lags; wait for a clock edge before testing it.
  task automatic drain_results();
    in_pix.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int burst_left;
    int gap;
    in_pix.valid      <= 1'b0;
    in_pix.hue        <= '0;
    in_pix.saturation <= '0;
    in_pix.brightness <= '0;
    rst_n             <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_pixel(DIRECTED[i][47:32], DIRECTED[i][31:16], DIRECTED[i][15:0]);
    end
    drain_results();

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        in_pix.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      send_pixel(pick_field(1'b1), pick_field(1'b0), pick_field(1'b0));
      if ($urandom_range(0, 199) == 0) begin
        drain_results();
      end
    end

    drain_results();
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
